// File: rtl/rrts_pkg.sv
package rrts_pkg;

  localparam int NUM_TASKS = 4;
  localparam int SLOT_W    = $clog2(NUM_TASKS);
  localparam int TASK_W    = $clog2(NUM_TASKS + 1);

  localparam logic [1:0] ST_FREE   = 2'd0;
  localparam logic [1:0] ST_READY  = 2'd1;
  localparam logic [1:0] ST_SLEEP  = 2'd2;
  localparam logic [1:0] ST_EXITED = 2'd3;

  localparam logic [2:0] FN_SCHED  = 3'd0;
  localparam logic [2:0] FN_WRITE  = 3'd1;
  localparam logic [2:0] FN_FORK   = 3'd2;
  localparam logic [2:0] FN_GETPID = 3'd3;
  localparam logic [2:0] FN_EXIT   = 3'd4;
  localparam logic [2:0] FN_SLEEP  = 3'd5;

  localparam logic [20:0] CAP_RESET = 21'h10000;
  localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [15:0] PID_FIRST = 16'd2;
  localparam logic [15:0] PID_INIT  = 16'd1;

  localparam logic REG_CAP = 1'b0;

  typedef struct packed {
    logic latch;
    logic fscan;
    logic exec;
    logic scan_rd;
    logic load_out;
  } rrts_cmd_t;

  typedef struct packed {
    logic is_fork;
    logic free_hit;
    logic fidx_last;
    logic sidx_last;
    logic out_free;
  } rrts_stat_t;

endpackage

// File: rtl/rrts_in_if.sv
interface rrts_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [63:0] arg_first;
  logic [63:0] write_length;
  logic signed [21:0] stack_used;

  modport source (output valid, func, arg_first, write_length, stack_used, input ready);
  modport sink (input valid, func, arg_first, write_length, stack_used, output ready);
endinterface

// File: rtl/rrts_out_if.sv
interface rrts_out_if #(
  parameter int TASK_W = 3,
  parameter int SLOT_W = 2
);
  logic              valid;
  logic              ready;
  logic [63:0]       ret_value;
  logic              ret_valid;
  logic [TASK_W-1:0] next_task;
  logic [SLOT_W-1:0] child_slot;
  logic              child_valid;
  logic              all_stopped;

  modport source (output valid, ret_value, ret_valid, next_task, child_slot, child_valid,
                  all_stopped, input ready);
  modport sink (input valid, ret_value, ret_valid, next_task, child_slot, child_valid,
                all_stopped, output ready);
endinterface

// File: rtl/rrts_ram.sv
module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/rrts_ctrl.sv
module rrts_ctrl import rrts_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  rrts_stat_t stat,
  output rrts_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FSCAN = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
        if (in_valid) begin
          state_nxt = S_FSCAN;
        end
      end
      S_FSCAN: begin
        cmd.fscan = stat.is_fork;
        if (!stat.is_fork || stat.free_hit || stat.fidx_last) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.sidx_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.load_out = stat.out_free;
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/rrts_dp.sv
module rrts_dp import rrts_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  rrts_cmd_t          cmd,
  output rrts_stat_t         stat,
  input  logic [20:0]        stack_capacity,
  input  logic [2:0]         in_func,
  input  logic [63:0]        in_arg_first,
  input  logic [63:0]        in_write_length,
  input  logic [21:0]        in_stack_used,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [63:0]        out_ret_value,
  output logic               out_ret_valid,
  output logic [TASK_W-1:0]  out_next_task,
  output logic [SLOT_W-1:0]  out_child_slot,
  output logic               out_child_valid,
  output logic               out_all_stopped
);

  localparam int AW = SLOT_W;
  localparam int TW = TASK_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_TASKS - 1);
  localparam logic [TW-1:0] IDLE_ID = TW'(NUM_TASKS);
  localparam logic [AW:0]   NUM_WIDE = (AW + 1)'(NUM_TASKS);

  logic [2:0]    func_r;
  logic [63:0]   arg_r;
  logic [63:0]   wlen_r;
  logic [21:0]   su_r;
  logic [TW-1:0] cur_r;
  logic [63:0]   tick_r;
  logic [AW-1:0] rr_r;
  logic [15:0]   pidc_r;
  logic [1:0]    st_r [NUM_TASKS];
  logic [AW-1:0] fidx_r;
  logic [AW-1:0] found_r;
  logic          found_ok_r;
  logic [AW-1:0] j_r;
  logic [AW-1:0] id_r;
  logic          rd_pend_r;
  logic [AW-1:0] pick_r;
  logic          pick_ok_r;
  logic          alive_r;
  logic [63:0]   ret_r;
  logic          ret_ok_r;
  logic [AW-1:0] child_r;
  logic          child_ok_r;
  logic          out_valid_r;
  logic [63:0]   out_ret_r;
  logic          out_ret_ok_r;
  logic [TW-1:0] out_next_r;
  logic [AW-1:0] out_child_r;
  logic          out_child_ok_r;
  logic          out_stop_r;

  logic [63:0]   ret_nxt;
  logic          ret_ok_nxt;
  logic [AW-1:0] child_nxt;
  logic          child_ok_nxt;

  logic          active;
  logic [AW-1:0] cur_idx;
  logic [AW:0]   idx_sum;
  logic [AW-1:0] scan_idx;
  logic [1:0]    st_rd;
  logic [AW-1:0] st_addr;
  logic          due;
  logic          woke;
  logic          slot_rdy;
  logic          stack_bad;
  logic [63:0]   wake_q;
  logic [15:0]   pid_q;
  logic          wake_we;
  logic          pid_we;

  assign cur_idx  = cur_r[AW-1:0];
  assign active   = (cur_r < IDLE_ID) && (func_r != FN_SCHED);
  assign idx_sum  = {1'b0, rr_r} + {1'b0, j_r};
  assign scan_idx = (idx_sum >= NUM_WIDE) ? AW'(idx_sum - NUM_WIDE) : idx_sum[AW-1:0];
  assign st_addr  = rd_pend_r ? id_r : fidx_r;
  assign st_rd    = st_r[st_addr];
  assign due      = wake_q <= tick_r;
  assign woke     = (st_rd == ST_SLEEP) && due;
  assign slot_rdy = (st_rd == ST_READY) || woke;
  assign stack_bad = su_r[21] || (su_r[20:0] > stack_capacity);

  assign wake_we = cmd.exec && active && (func_r == FN_SLEEP);
  assign pid_we  = cmd.exec && active && (func_r == FN_FORK) && found_ok_r && !stack_bad;

  rrts_ram #(.WIDTH(64), .DEPTH(NUM_TASKS)) u_wake_ram (
    .clk   (clk),
    .we    (wake_we),
    .waddr (cur_idx),
    .wdata (tick_r + arg_r),
    .raddr (scan_idx),
    .rdata (wake_q)
  );

  rrts_ram #(.WIDTH(16), .DEPTH(NUM_TASKS)) u_pid_ram (
    .clk   (clk),
    .we    (pid_we),
    .waddr (found_r),
    .wdata (pidc_r),
    .raddr (cur_idx),
    .rdata (pid_q)
  );

  assign stat.is_fork   = active && (func_r == FN_FORK);
  assign stat.free_hit  = st_rd == ST_FREE;
  assign stat.fidx_last = fidx_r == LAST_IDX;
  assign stat.sidx_last = j_r == LAST_IDX;
  assign stat.out_free  = !out_valid_r || out_ready;

  always_comb begin
    ret_nxt      = 64'd0;
    ret_ok_nxt   = 1'b0;
    child_nxt    = '0;
    child_ok_nxt = 1'b0;
    if (active) begin
      ret_ok_nxt = 1'b1;
      case (func_r)
        FN_WRITE: begin
          ret_nxt = (arg_r[31:0] == 32'd1) ? wlen_r : 64'd0;
        end
        FN_FORK: begin
          if (!found_ok_r || stack_bad) begin
            ret_nxt = ALL_ONES;
          end else begin
            ret_nxt      = {48'd0, pidc_r};
            child_nxt    = found_r;
            child_ok_nxt = 1'b1;
          end
        end
        FN_GETPID: begin
          ret_nxt = (cur_idx == '0) ? {48'd0, PID_INIT} : {48'd0, pid_q};
        end
        FN_EXIT: begin
          ret_ok_nxt = 1'b0;
        end
        FN_SLEEP: begin
          ret_nxt = 64'd0;
        end
        default: begin
          ret_nxt = ALL_ONES;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r <= in_func;
      arg_r  <= in_arg_first;
      wlen_r <= in_write_length;
      su_r   <= in_stack_used;
    end
    if (cmd.fscan && stat.free_hit) begin
      found_r <= fidx_r;
    end
    if (cmd.scan_rd) begin
      id_r <= scan_idx;
    end
    if (rd_pend_r && slot_rdy && !pick_ok_r) begin
      pick_r <= id_r;
    end
    if (cmd.exec) begin
      ret_r      <= ret_nxt;
      ret_ok_r   <= ret_ok_nxt;
      child_r    <= child_nxt;
      child_ok_r <= child_ok_nxt;
    end
    if (cmd.load_out) begin
      out_ret_r      <= ret_ok_r ? ret_r : 64'd0;
      out_ret_ok_r   <= ret_ok_r;
      out_next_r     <= pick_ok_r ? TW'(pick_r) : IDLE_ID;
      out_child_r    <= child_r;
      out_child_ok_r <= child_ok_r;
      out_stop_r     <= !alive_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      tick_r      <= 64'd0;
      rr_r        <= '0;
      pidc_r      <= PID_FIRST;
      fidx_r      <= '0;
      found_ok_r  <= 1'b0;
      j_r         <= '0;
      rd_pend_r   <= 1'b0;
      pick_ok_r   <= 1'b0;
      alive_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        st_r[i] <= (i == 0) ? ST_READY : ST_FREE;
      end
    end else begin
      rd_pend_r <= cmd.scan_rd;
      if (cmd.latch) begin
        fidx_r     <= '0;
        found_ok_r <= 1'b0;
      end
      if (cmd.fscan) begin
        if (stat.free_hit) begin
          found_ok_r <= 1'b1;
        end else if (!stat.fidx_last) begin
          fidx_r <= fidx_r + 1'b1;
        end
      end
      if (cmd.exec) begin
        tick_r    <= tick_r + 64'd1;
        j_r       <= '0;
        pick_ok_r <= 1'b0;
        alive_r   <= 1'b0;
        if (active) begin
          case (func_r)
            FN_FORK: begin
              if (found_ok_r) begin
                pidc_r <= pidc_r + 16'd1;
                if (!stack_bad) begin
                  st_r[found_r] <= ST_READY;
                end
              end
            end
            FN_EXIT: begin
              st_r[cur_idx] <= ST_EXITED;
            end
            FN_SLEEP: begin
              st_r[cur_idx] <= ST_SLEEP;
            end
            default: begin
            end
          endcase
        end
      end
      if (cmd.scan_rd && !stat.sidx_last) begin
        j_r <= j_r + 1'b1;
      end
      if (rd_pend_r) begin
        if (woke) begin
          st_r[id_r] <= ST_READY;
        end
        if (slot_rdy) begin
          pick_ok_r <= 1'b1;
        end
        if ((st_rd == ST_READY) || (st_rd == ST_SLEEP)) begin
          alive_r <= 1'b1;
        end
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
        if (pick_ok_r) begin
          cur_r <= TW'(pick_r);
          rr_r  <= (pick_r == LAST_IDX) ? '0 : pick_r + 1'b1;
        end else begin
          cur_r <= IDLE_ID;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ret_value   = out_ret_r;
  assign out_ret_valid   = out_ret_ok_r;
  assign out_next_task   = out_next_r;
  assign out_child_slot  = out_child_r;
  assign out_child_valid = out_child_ok_r;
  assign out_all_stopped = out_stop_r;

endmodule

// File: rtl/round_robin_task_scheduler.sv
// Channel   Direction  Handshake      Contents
// in_ch     sink       valid/ready    func, arg_first, write_length, stack_used
// out_ch    source     valid/ready    ret_value, ret_valid, next_task, child_slot,
//                                     child_valid, all_stopped
// APB       slave      psel/penable   stack_capacity at byte address 0
//
// Each request scans the task table one slot per cycle, and a fork first scans it
// one slot per cycle for a free slot as well.
// One request is in flight at a time; in_ch.ready is high only while idle.
// Reset is synchronous and active low; slot 0 starts ready with pid 1.
// A result held by a low out_ch.ready blocks the next request from finishing.
module round_robin_task_scheduler import rrts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  rrts_in_if.sink     in_ch,
  rrts_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = SLOT_W;
  localparam int TW = TASK_W;

  logic [20:0] cap_r;
  rrts_cmd_t   cmd;
  rrts_stat_t  stat;
  logic [TW-1:0] next_task;
  logic [AW-1:0] child_slot;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAP) ? {11'd0, cap_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_CAP)) begin
      cap_r <= pwdata[20:0];
    end
  end

  rrts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rrts_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .stack_capacity  (cap_r),
    .in_func         (in_ch.func),
    .in_arg_first    (in_ch.arg_first),
    .in_write_length (in_ch.write_length),
    .in_stack_used   (in_ch.stack_used),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_ret_value   (out_ch.ret_value),
    .out_ret_valid   (out_ch.ret_valid),
    .out_next_task   (next_task),
    .out_child_slot  (child_slot),
    .out_child_valid (out_ch.child_valid),
    .out_all_stopped (out_ch.all_stopped)
  );

  assign out_ch.next_task  = next_task;
  assign out_ch.child_slot = child_slot;

endmodule

// File: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rrts_pkg::*;

  localparam int NTASK = NUM_TASKS;
  localparam logic [2:0] IDLE_SLOT = 3'd4;
  localparam logic [2:0] FN_ODD6 = 3'd6;
  localparam logic [2:0] FN_ODD7 = 3'd7;
  localparam logic [2:0] CAP_ADDR = {REG_CAP, 2'b00};
  localparam logic [20:0] CAP_MIN = 21'd1;
  localparam logic [20:0] CAP_MAX = 21'h100000;
  localparam int STALL_LEN = 300;
  localparam int NPLAN = 22;
  localparam int PHASE_LEN = 125;
  localparam int TAIL_LEN = 60;
  localparam int SETTLE = 2 * NTASK + 8;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] arg;
    logic [63:0] wlen;
    logic [21:0] su;
  } sched_req_t;

  typedef struct packed {
    logic [63:0] ret;
    logic        ret_ok;
    logic [2:0]  next;
    logic [1:0]  child;
    logic        child_ok;
    logic        stopped;
  } sched_res_t;

  typedef struct packed {
    sched_req_t req;
    logic       typed;
    sched_res_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  rrts_in_if in_if ();
  rrts_out_if out_if ();

  round_robin_task_scheduler uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_if),
    .out_ch(out_if),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [1:0]  task_state [NTASK];
  logic [63:0] wake_at [NTASK];
  logic [15:0] task_pid [NTASK];
  logic [63:0] ticks;
  logic [1:0]  rr_next;
  logic [15:0] pid_ctr;
  logic [2:0]  cur_slot;
  logic [20:0] stack_cap;

  sched_res_t pending_returns [$];
  row_t plan [NPLAN];
  int errors = 0;
  bit calm = 1'b0;
  int stall_asked = 0;
  int stall_taken = 0;
  int hold_left = 0;

  function automatic void clear_model();
    for (int i = 0; i < NTASK; i++) begin
      task_state[i] = ST_FREE;
      wake_at[i] = '0;
      task_pid[i] = '0;
    end
    task_state[0] = ST_READY;
    task_pid[0] = PID_INIT;
    ticks = '0;
    rr_next = '0;
    pid_ctr = PID_FIRST;
    cur_slot = '0;
    stack_cap = CAP_RESET;
  endfunction

  function automatic logic tasks_stopped();
    for (int i = 0; i < NTASK; i++) begin
      if (task_state[i] == ST_READY || task_state[i] == ST_SLEEP) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic sched_res_t advance_scheduler(sched_req_t r);
    sched_res_t res;
    int free_slot;
    int idx;
    logic [15:0] pid;
    logic [2:0] pick;
    res = '0;
    if (cur_slot < NTASK && r.func != FN_SCHED) begin
      res.ret_ok = 1'b1;
      case (r.func)
        FN_WRITE: begin
          res.ret = (r.arg[31:0] == 32'd1) ? r.wlen : 64'd0;
        end
        FN_FORK: begin
          free_slot = NTASK;
          for (int i = NTASK - 1; i >= 0; i--) begin
            if (task_state[i] == ST_FREE) free_slot = i;
          end
          if (free_slot == NTASK) begin
            res.ret = ALL_ONES;
          end else begin
            pid = pid_ctr;
            pid_ctr = pid_ctr + 16'd1;
            if (r.su[21] || r.su[20:0] > stack_cap) begin
              res.ret = ALL_ONES;
            end else begin
              task_state[free_slot] = ST_READY;
              task_pid[free_slot] = pid;
              res.ret = {48'd0, pid};
              res.child = 2'(free_slot);
              res.child_ok = 1'b1;
            end
          end
        end
        FN_GETPID: begin
          res.ret = {48'd0, task_pid[cur_slot]};
        end
        FN_EXIT: begin
          task_state[cur_slot] = ST_EXITED;
          res.ret_ok = 1'b0;
        end
        FN_SLEEP: begin
          task_state[cur_slot] = ST_SLEEP;
          wake_at[cur_slot] = ticks + r.arg;
        end
        default: begin
          res.ret = ALL_ONES;
        end
      endcase
    end
    ticks = ticks + 64'd1;
    for (int i = 0; i < NTASK; i++) begin
      if (task_state[i] == ST_SLEEP && wake_at[i] <= ticks) task_state[i] = ST_READY;
    end
    pick = IDLE_SLOT;
    for (int n = NTASK - 1; n >= 0; n--) begin
      idx = (int'(rr_next) + n) % NTASK;
      if (task_state[idx] == ST_READY) pick = 3'(idx);
    end
    if (pick != IDLE_SLOT) rr_next = 2'(pick + 3'd1);
    cur_slot = pick;
    res.next = pick;
    res.stopped = tasks_stopped();
    return res;
  endfunction

  function automatic row_t plan_row(logic [2:0] f, logic [63:0] a, logic [63:0] w,
                                    logic [21:0] s, logic typed, logic [63:0] ret,
                                    logic ret_ok);
    row_t row;
    row.req = '{f, a, w, s};
    row.typed = typed;
    row.want = '{ret, ret_ok, 3'd0, 2'd0, 1'b0, 1'b0};
    return row;
  endfunction

  function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, what, want, got);
      errors++;
    end
  endfunction

  function automatic sched_req_t rand_call(bit tail);
    sched_req_t r;
    int pick;
    r.func = FN_SCHED;
    r.arg = {$urandom, $urandom};
    r.wlen = {$urandom, $urandom};
    r.su = 22'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      r.func = FN_SCHED;
    end else if (pick < 30) begin
      r.func = FN_WRITE;
      if ($urandom_range(0, 3) != 0) r.arg[31:0] = 32'd1;
      if ($urandom_range(0, 7) == 0) r.wlen = ($urandom_range(0, 1) != 0) ? ALL_ONES : 64'd0;
    end else if (pick < 48) begin
      r.func = FN_FORK;
      case ($urandom_range(0, 3))
        0: r.su = 22'($urandom_range(0, stack_cap));
        1: r.su = {1'b0, stack_cap} + 22'($urandom_range(0, 1));
        default: ;
      endcase
    end else if (pick < 62) begin
      r.func = FN_GETPID;
    end else if (pick < 85) begin
      r.func = FN_SLEEP;
      if (tail || $urandom_range(0, 9) != 0) r.arg = 64'($urandom_range(0, 12));
      else r.arg = ALL_ONES - 64'($urandom_range(0, 20));
    end else if (pick < 93) begin
      r.func = ($urandom_range(0, 1) != 0) ? FN_ODD7 : FN_ODD6;
    end else begin
      r.func = tail ? FN_EXIT : FN_SCHED;
    end
    return r;
  endfunction

  task automatic send_call(input sched_req_t r, input logic typed, input sched_res_t typed_res);
    sched_res_t res;
    if (!calm) begin
      while ($urandom_range(0, 99) < 33) begin
        in_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_if.valid <= 1'b1;
    in_if.func <= r.func;
    in_if.arg_first <= r.arg;
    in_if.write_length <= r.wlen;
    in_if.stack_used <= r.su;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    res = advance_scheduler(r);
    pending_returns.push_back(typed ? typed_res : res);
  endtask

  task automatic run_calls(input int count, input bit tail);
    repeat (count) send_call(rand_call(tail), 1'b0, '0);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_returns.size() != 0) @(posedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= CAP_ADDR;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_capacity();
    logic [31:0] rdata;
    apb_xfer(1'b0, '0, rdata);
    check_field("stack_capacity", 64'(stack_cap), 64'(rdata[20:0]));
  endtask

  task automatic set_capacity(input logic [20:0] cap);
    logic [31:0] rdata;
    apb_xfer(1'b1, {11'($urandom), cap}, rdata);
    stack_cap = cap;
    check_capacity();
  endtask

  always @(posedge clk) begin : result_side
    sched_res_t want;
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_returns.size() == 0) begin
        $display("%0t: unexpected request result, ret_value %h", $time, out_if.ret_value);
        errors++;
      end else begin
        want = pending_returns.pop_front();
        check_field("ret_value", want.ret, out_if.ret_value);
        check_field("ret_valid", 64'(want.ret_ok), 64'(out_if.ret_valid));
        check_field("next_task", 64'(want.next), 64'(out_if.next_task));
        check_field("child_slot", 64'(want.child), 64'(out_if.child_slot));
        check_field("child_valid", 64'(want.child_ok), 64'(out_if.child_valid));
        check_field("all_stopped", 64'(want.stopped), 64'(out_if.all_stopped));
      end
    end
    if (stall_asked != stall_taken) begin
      stall_taken = stall_asked;
      hold_left = STALL_LEN;
    end
    if (rst_n !== 1'b1) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= calm || ($urandom_range(0, 99) >= 33);
    end
  end

  initial begin : stimulus
    sched_req_t r;
    rst_n <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_if.valid <= 1'b0;
    in_if.func <= FN_SCHED;
    in_if.arg_first <= '0;
    in_if.write_length <= '0;
    in_if.stack_used <= '0;
    clear_model();

    // Slot 0 is the only task until the fork at the stack limit succeeds.
    plan = '{
      plan_row(FN_GETPID, 64'd0, 64'd0, 22'd0, 1'b1, 64'd1, 1'b1),
      plan_row(FN_WRITE, 64'd1, ALL_ONES, 22'd0, 1'b1, ALL_ONES, 1'b1),
      plan_row(FN_WRITE, 64'hFFFF_FFFF_0000_0001, 64'h8000_0000_0000_0001, 22'd0, 1'b0,
               64'd0, 1'b0),
      plan_row(FN_WRITE, 64'h0000_0001_0000_0000, 64'h1234, 22'd0, 1'b0, 64'd0, 1'b0),
      plan_row(FN_ODD6, ALL_ONES, ALL_ONES, 22'h3FFFFF, 1'b1, ALL_ONES, 1'b1),
      plan_row(FN_ODD7, 64'd0, 64'd0, 22'd0, 1'b1, ALL_ONES, 1'b1),
      plan_row(FN_SCHED, ALL_ONES, ALL_ONES, 22'h3FFFFF, 1'b1, 64'd0, 1'b0),
      plan_row(FN_FORK, 64'd0, 64'd0, 22'h3FFFFF, 1'b1, ALL_ONES, 1'b1),
      plan_row(FN_FORK, 64'd0, 64'd0, 22'h200000, 1'b1, ALL_ONES, 1'b1),
      plan_row(FN_FORK, 64'd0, 64'd0, 22'h010001, 1'b1, ALL_ONES, 1'b1),
      plan_row(FN_FORK, 64'd0, 64'd0, 22'h1FFFFF, 1'b1, ALL_ONES, 1'b1),
      plan_row(FN_FORK, 64'd0, 64'd0, 22'h010000, 1'b0, 64'd0, 1'b0),
      plan_row(FN_GETPID, 64'd0, 64'd0, 22'd0, 1'b0, 64'd0, 1'b0),
      plan_row(FN_SLEEP, 64'd0, 64'd0, 22'd0, 1'b0, 64'd0, 1'b0),
      plan_row(FN_SLEEP, ALL_ONES, 64'd0, 22'd0, 1'b0, 64'd0, 1'b0),
      plan_row(FN_SLEEP, 64'd6, 64'd0, 22'd0, 1'b0, 64'd0, 1'b0),
      plan_row(FN_WRITE, 64'd1, 64'd77, 22'd0, 1'b0, 64'd0, 1'b0),
      plan_row(FN_SLEEP, 64'd4, 64'd0, 22'd0, 1'b0, 64'd0, 1'b0),
      plan_row(FN_WRITE, 64'd1, 64'd99, 22'd0, 1'b0, 64'd0, 1'b0),
      plan_row(FN_FORK, 64'd0, 64'd0, 22'd0, 1'b0, 64'd0, 1'b0),
      plan_row(FN_GETPID, 64'd0, 64'd0, 22'd0, 1'b0, 64'd0, 1'b0),
      plan_row(FN_EXIT, 64'd0, 64'd0, 22'd0, 1'b0, 64'd0, 1'b0)
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_capacity();

    foreach (plan[i]) send_call(plan[i].req, plan[i].typed, plan[i].want);

    drain();
    set_capacity(CAP_MIN);
    stall_asked++;
    run_calls(PHASE_LEN, 1'b0);
    drain();
    set_capacity(CAP_MAX);
    calm = 1'b1;
    run_calls(PHASE_LEN, 1'b0);
    calm = 1'b0;
    drain();
    set_capacity(21'($urandom_range(2, CAP_MAX - 1)));
    run_calls(PHASE_LEN, 1'b0);
    run_calls(TAIL_LEN, 1'b1);
    while (!tasks_stopped()) begin
      r = rand_call(1'b1);
      r.func = FN_EXIT;
      send_call(r, 1'b0, '0);
    end
    run_calls(6, 1'b0);
    drain();
    repeat (SETTLE) @(posedge clk);

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #50_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: sim.f
rtl/rrts_pkg.sv
rtl/rrts_in_if.sv
rtl/rrts_out_if.sv
rtl/rrts_ram.sv
rtl/rrts_ctrl.sv
rtl/rrts_dp.sv
rtl/round_robin_task_scheduler.sv
tb/tb_top.sv
